>>> rtl/byte_stuffed_frame_receiver_assert.svh
// assertion macros for the byte stuffed frame receiver
`ifndef BYTE_STUFFED_FRAME_RECEIVER_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define BSFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsfr assertion failed");

// next-cycle implication, checked out of reset
`define BSFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsfr assertion failed");

`else

`define BSFR_ASSERT_IMPL(lbl, ante, cons)
`define BSFR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/bsfr_pkg.sv
// shared constants and types for the byte stuffed frame receiver
package bsfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 10;

  // default frame capacity in stored bytes
  localparam int unsigned FRAME_CAPACITY_DEF = 512 + 8;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

  // fletcher modulus
  localparam logic [BYTE_W:0] FL_MOD = 9'd255;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] byte_index;
    logic               frame_good;
    logic [COUNT_W-1:0] payload_length;
  } res_t;

endpackage

>>> rtl/bsfr_in_if.sv
// input channel: raw received bytes
interface bsfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/bsfr_out_if.sv
// result channel: decoded data bytes and end of frame status
interface bsfr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bsfr_pkg::BYTE_W-1:0]  data_byte;
  logic [bsfr_pkg::COUNT_W-1:0] byte_index;
  logic                         frame_good;
  logic [bsfr_pkg::COUNT_W-1:0] payload_length;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output frame_good, output payload_length, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input frame_good, input payload_length, output ready);
endinterface

>>> rtl/bsfr_in_stage.sv
// input register stage holding one raw byte
module bsfr_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  bsfr_in_if.sink                     in_ch,
  input  logic                        stg_take,
  output logic                        stg_valid,
  output logic [bsfr_pkg::BYTE_W-1:0] stg_byte
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [bsfr_pkg::BYTE_W-1:0] byte_r;

  // free when empty or drained this cycle
  assign in_ch.ready = !valid_r || stg_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end else if (stg_take) begin
      valid_nxt = 1'b0;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign stg_valid = valid_r;
  assign stg_byte  = byte_r;

endmodule

>>> rtl/bsfr_decoder.sv
// unstuffing state machine with running fletcher-16 sums
module bsfr_decoder #(
  parameter int unsigned FRAME_CAPACITY = bsfr_pkg::FRAME_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [bsfr_pkg::BYTE_W-1:0] rx_byte,
  output logic                        res_valid,
  output bsfr_pkg::res_t              res
);

  localparam int unsigned BW = bsfr_pkg::BYTE_W;
  localparam int unsigned CW = bsfr_pkg::COUNT_W;

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } mode_t;

  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] lo_r, lo_nxt;
  logic [BW-1:0] hi_r, hi_nxt;

  logic          hunting;
  logic [CW-1:0] base_cnt;
  logic [BW-1:0] base_lo;
  logic [BW-1:0] base_hi;
  logic [BW-1:0] st_data;
  logic [BW:0]   lo_add;
  logic [BW-1:0] lo_new;
  logic [BW:0]   hi_add;
  logic [BW-1:0] hi_new;
  logic          room;
  logic          do_store;
  logic          good;

  // a frame start sees cleared count and sums
  assign hunting  = (mode_r != MODE_FRAME) && (mode_r != MODE_ESC);
  assign base_cnt = hunting ? '0 : cnt_r;
  assign base_lo  = hunting ? '0 : lo_r;
  assign base_hi  = hunting ? '0 : hi_r;
  assign st_data  = (mode_r == MODE_ESC) ? (rx_byte ^ bsfr_pkg::ESC_XOR) : rx_byte;

  // fletcher update, one conditional subtract per sum
  assign lo_add = {1'b0, base_lo} + {1'b0, st_data};
  assign lo_new = (lo_add >= bsfr_pkg::FL_MOD) ? BW'(lo_add - bsfr_pkg::FL_MOD)
                                                : lo_add[BW-1:0];
  assign hi_add = {1'b0, base_hi} + {1'b0, lo_new};
  assign hi_new = (hi_add >= bsfr_pkg::FL_MOD) ? BW'(hi_add - bsfr_pkg::FL_MOD)
                                                : hi_add[BW-1:0];
  assign room   = 32'(base_cnt) < FRAME_CAPACITY;

  // close check on the running frame
  assign good = (cnt_r >= CW'(3)) && (lo_r == '0) && (hi_r == '0);

  // next state and result
  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    do_store  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    unique case (mode_r)
      MODE_FRAME: begin
        if (rx_byte == bsfr_pkg::FLAG_BYTE) begin
          res_valid          = 1'b1;
          res.kind           = bsfr_pkg::KIND_STATUS;
          res.frame_good     = good;
          res.payload_length = good ? (cnt_r - CW'(2)) : '0;
          mode_nxt           = MODE_HUNT;
          cnt_nxt            = '0;
          lo_nxt             = '0;
          hi_nxt             = '0;
        end else if (rx_byte == bsfr_pkg::ESC_BYTE) begin
          mode_nxt = MODE_ESC;
        end else begin
          do_store = 1'b1;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_FRAME;
        do_store = 1'b1;
      end
      default: begin
        // hunting, and the unused code behaves the same
        if (rx_byte == bsfr_pkg::FLAG_BYTE) begin
          mode_nxt = MODE_HUNT;
        end else begin
          cnt_nxt = '0;
          lo_nxt  = '0;
          hi_nxt  = '0;
          if (rx_byte == bsfr_pkg::ESC_BYTE) begin
            mode_nxt = MODE_ESC;
          end else begin
            mode_nxt = MODE_FRAME;
            do_store = 1'b1;
          end
        end
      end
    endcase
    // store unless the frame is full
    if (do_store && room) begin
      res_valid      = 1'b1;
      res.kind       = bsfr_pkg::KIND_DATA;
      res.data_byte  = st_data;
      res.byte_index = base_cnt;
      cnt_nxt        = base_cnt + CW'(1);
      lo_nxt         = lo_new;
      hi_nxt         = hi_new;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HUNT;
      cnt_r  <= '0;
      lo_r   <= '0;
      hi_r   <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
    end
  end

endmodule

>>> rtl/bsfr_out_reg.sv
// result register driving the output channel
module bsfr_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load_valid,
  input  bsfr_pkg::res_t load_res,
  output logic           up_ready,
  bsfr_out_if.source     out_ch
);

  logic           valid_r;
  logic           valid_nxt;
  bsfr_pkg::res_t res_r;

  // room when empty or the held beat leaves now
  assign up_ready = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = load_valid;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (up_ready && load_valid) begin
      res_r <= load_res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.data_byte      = res_r.data_byte;
  assign out_ch.byte_index     = res_r.byte_index;
  assign out_ch.frame_good     = res_r.frame_good;
  assign out_ch.payload_length = res_r.payload_length;

endmodule

>>> rtl/byte_stuffed_frame_receiver.sv
// Byte stuffed frame receiver: takes one raw serial byte per beat, drops flag
// bytes 0x7E while hunting, removes 0x7D escapes (the next byte is XORed with
// 0x20, also when the escape opens the frame) and emits every stored byte with
// its index in the frame. A flag inside a frame closes it with one status beat:
// frame_good is set when at least three bytes were stored and the Fletcher-16
// sums (mod 255) over them are both zero, and payload_length is then the
// stored count minus two, else zero. Bytes past FRAME_CAPACITY are dropped with
// no beat. Each byte passes an input register, combinational decode logic and a
// result register, so a byte is accepted every cycle while the output side keeps
// taking beats, and a result that the byte yields is registered in the result
// register that drives the output. A stalled output holds the result register,
// which holds the input register and with it the input side.
`include "byte_stuffed_frame_receiver_assert.svh"

module byte_stuffed_frame_receiver #(
  parameter int unsigned FRAME_CAPACITY = bsfr_pkg::FRAME_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bsfr_in_if.sink    in_ch,
  bsfr_out_if.source out_ch
);

  logic                        stg_valid;
  logic [bsfr_pkg::BYTE_W-1:0] stg_byte;
  logic                        up_ready;
  logic                        dec_fire;
  logic                        res_valid;
  bsfr_pkg::res_t              res;
  logic                        beat_status;
  logic                        beat_data;

  // decode fires when a byte is staged and the result register has room
  assign dec_fire = stg_valid && up_ready;

  bsfr_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .stg_take  (dec_fire),
    .stg_valid (stg_valid),
    .stg_byte  (stg_byte)
  );

  bsfr_decoder #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (dec_fire),
    .rx_byte   (stg_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  bsfr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (dec_fire && res_valid),
    .load_res   (res),
    .up_ready   (up_ready),
    .out_ch     (out_ch)
  );

  // kind of the beat on the output
  assign beat_status = out_ch.valid && (out_ch.kind == bsfr_pkg::KIND_STATUS);
  assign beat_data   = out_ch.valid && (out_ch.kind == bsfr_pkg::KIND_DATA);

  // checks
  `BSFR_ASSERT_IMPL(a_bad_len_zero, beat_status && !out_ch.frame_good, out_ch.payload_length == '0)
  `BSFR_ASSERT_IMPL(a_good_len_nonzero, beat_status && out_ch.frame_good, out_ch.payload_length != '0)
  `BSFR_ASSERT_IMPL(a_index_in_cap, beat_data, 32'(out_ch.byte_index) < FRAME_CAPACITY)
  `BSFR_ASSERT_NEXT(a_stage_holds, stg_valid && !dec_fire, stg_valid)

endmodule
